>>> rtl/positional_list_engine_top_defines.svh
// Assertion macros for the positional list engine RTL
`ifndef POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define PLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ple_pkg.sv
// Shared types and constants for the positional list engine
package ple_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_INSERT = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic req_load;  // capture the accepted request
    logic exec;      // apply the request and load the result register
  } ple_cmd_t;

endpackage

>>> rtl/ple_ctrl.sv
// Sequencer for the positional list engine: request intake and result handshake
module ple_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ple_pkg::ple_cmd_t cmd
);
  import ple_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Result register can take a new result this cycle
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_stall     = 1'b1;
    cmd.req_load = 1'b0;
    cmd.exec     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall     = 1'b0;
        cmd.req_load = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Hold the result until its transfer, load a fresh one on execute
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/ple_dp.sv
// Datapath for the positional list engine: cell chain, count and result register
module ple_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [ple_pkg::OP_W-1:0]          in_opcode,
  input  logic [ple_pkg::POS_W-1:0]         in_position,
  input  logic signed [ple_pkg::VAL_W-1:0]  in_value,
  input  ple_pkg::ple_cmd_t                 cmd,
  output logic                              out_ok,
  output logic signed [ple_pkg::VAL_W-1:0]  out_data,
  output logic [ple_pkg::COUNT_W-1:0]       out_count,
  output logic                              out_empty_res
);
  import ple_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int unsigned RD_N  = (CAPACITY < (2**POS_W - 1)) ? CAPACITY : (2**POS_W - 1);

  // Request registers
  op_t                     op_r;
  logic [POS_W-1:0]        pos_r;
  logic signed [VAL_W-1:0] val_r;

  // List state
  logic signed [VAL_W-1:0] cells_r [CAPACITY];
  logic [CNT_W-1:0]        count_r, count_nxt;

  // Result register
  logic                    ok_r;
  logic signed [VAL_W-1:0] data_r;
  logic [COUNT_W-1:0]      rcount_r;
  logic                    empty_r;

  logic [CMP_W-1:0]        pos_x, cnt_x, idx_x;
  logic [POS_W-1:0]        idx;
  logic                    in_range, ins_ok;
  logic                    do_ins, do_wr, do_rem, ok_c, ret_data;
  logic signed [VAL_W-1:0] rd_data;
  logic [CMP_W-1:0]        cnt_nxt_x;

  // Capture the request on its transfer
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      op_r  <= op_t'(in_opcode);
      pos_r <= in_position;
      val_r <= in_value;
    end
  end

  // Decode range checks
  assign pos_x    = CMP_W'(pos_r);
  assign cnt_x    = CMP_W'(count_r);
  assign idx      = pos_r - POS_W'(1);
  assign idx_x    = CMP_W'(idx);
  assign in_range = (pos_r != '0) && (pos_x <= cnt_x);
  assign ins_ok   = (pos_r != '0) && (pos_x <= (cnt_x + CMP_W'(1)))
                    && (count_r != CNT_W'(CAPACITY));

  always_comb begin
    do_ins   = 1'b0;
    do_wr    = 1'b0;
    do_rem   = 1'b0;
    ok_c     = 1'b0;
    ret_data = 1'b0;
    unique case (op_r)
      OP_READ: begin
        ok_c     = in_range;
        ret_data = in_range;
      end
      OP_WRITE: begin
        ok_c  = in_range;
        do_wr = in_range;
      end
      OP_INSERT: begin
        ok_c   = ins_ok;
        do_ins = ins_ok;
      end
      OP_REMOVE: begin
        ok_c     = in_range;
        do_rem   = in_range;
        ret_data = in_range;
      end
      default: ok_c = 1'b0;
    endcase
  end

  // Select the addressed cell
  always_comb begin
    rd_data = '0;
    for (int k = 0; k < RD_N; k++) begin
      if (idx == POS_W'(k)) rd_data = cells_r[k];
    end
  end

  // Cell chain: each cell takes its neighbor on a shift, or the new value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] prev_val, next_val;

    if (i == 0) begin : g_first
      assign prev_val = val_r;
    end else begin : g_mid
      assign prev_val = cells_r[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_val = cells_r[i];
    end else begin : g_body
      assign next_val = cells_r[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        priority if (do_ins && (CMP_W'(i) > idx_x)) begin
          cells_r[i] <= prev_val;
        end else if ((do_ins || do_wr) && (CMP_W'(i) == idx_x)) begin
          cells_r[i] <= val_r;
        end else if (do_rem && (CMP_W'(i) >= idx_x)) begin
          cells_r[i] <= next_val;
        end else begin
          cells_r[i] <= cells_r[i];
        end
      end
    end
  end

  // Advance the entry count
  always_comb begin
    count_nxt = count_r;
    if (do_ins) count_nxt = count_r + CNT_W'(1);
    else if (do_rem) count_nxt = count_r - CNT_W'(1);
  end

  assign cnt_nxt_x = CMP_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_r     <= ok_c;
      data_r   <= ret_data ? rd_data : '0;
      rcount_r <= cnt_nxt_x[COUNT_W-1:0];
      empty_r  <= (count_nxt == '0);
    end
  end

  assign out_ok        = ok_r;
  assign out_data      = data_r;
  assign out_count     = rcount_r;
  assign out_empty_res = empty_r;

endmodule

>>> rtl/positional_list_engine_top.sv
// Top level of the positional list engine: sequencer plus cell-chain datapath
// A request is captured in the intake state and its result is loaded in the
// execute state, which waits while the previous result is still stalled.
// A new request is held off (in_stall) until the execute state has loaded
// the result of the request before it.
// Insert and remove shift the cells from the addressed position onward in execute.
// Reset (rst_n, synchronous): empties the list, clears control; no clearing pass.
`include "positional_list_engine_top_defines.svh"

module positional_list_engine_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ple_pkg::OP_W-1:0]          in_opcode,
  input  logic [ple_pkg::POS_W-1:0]         in_position,
  input  logic signed [ple_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_ok,
  output logic signed [ple_pkg::VAL_W-1:0]  out_data,
  output logic [ple_pkg::COUNT_W-1:0]       out_count,
  output logic                              out_empty_res
);
  import ple_pkg::*;

  ple_cmd_t cmd;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ple_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_opcode     (in_opcode),
    .in_position   (in_position),
    .in_value      (in_value),
    .cmd           (cmd),
    .out_ok        (out_ok),
    .out_data      (out_data),
    .out_count     (out_count),
    .out_empty_res (out_empty_res)
  );

  // Checks
  `PLE_ASSERT_NXT(a_busy_after_take, in_valid && !in_stall, in_stall, "intake not blocked")
  `PLE_ASSERT_NXT(a_exec_loads_result, cmd.exec, out_valid, "result not presented")
  `PLE_ASSERT_IMP(a_fail_zero_data, out_valid && !out_ok, out_data == '0, "failed op data")

endmodule

>>> bench/tb_positional_list_engine_top.sv
// Self-checking testbench for the positional list engine top level
module tb_positional_list_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int LIST_DEPTH  = 16;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 8;

  typedef struct {
    logic                     ok;
    logic signed [VAL_W-1:0]  data;
    logic [COUNT_W-1:0]       count;
    logic                     empty;
  } list_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [OP_W-1:0]          in_opcode;
  logic [POS_W-1:0]         in_position;
  logic signed [VAL_W-1:0]  in_value;
  logic                     out_valid;
  logic                     out_stall;
  logic                     out_ok;
  logic signed [VAL_W-1:0]  out_data;
  logic [COUNT_W-1:0]       out_count;
  logic                     out_empty_res;

  // Shadow copy of the list
  logic signed [VAL_W-1:0] list_mem [0:LIST_DEPTH-1];
  int                      list_len;

  list_result_t pending_results [$];

  int src_idle_pct;
  int snk_idle_pct;
  int hold_request;
  int n_requests;
  int n_checked;
  int n_errors;
  int n_full_refusals;
  int peak_len;
  int quiet_cycles;

  positional_list_engine_top #(
    .CAPACITY(LIST_DEPTH)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_position  (in_position),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ok       (out_ok),
    .out_data     (out_data),
    .out_count    (out_count),
    .out_empty_res(out_empty_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow list and return the result it must produce
  function automatic list_result_t apply_list_request(input op_t op,
                                                      input logic [POS_W-1:0] pos,
                                                      input logic signed [VAL_W-1:0] val);
    list_result_t r;
    int p;
    int i;
    r.ok = 1'b0;
    r.data = '0;
    p = int'(pos);
    if (op == OP_INSERT) begin
      if (list_len == LIST_DEPTH) begin
        n_full_refusals++;
      end
      if (p >= 1 && p <= list_len + 1 && list_len < LIST_DEPTH) begin
        for (i = list_len; i >= p; i--) begin
          list_mem[i] = list_mem[i-1];
        end
        list_mem[p-1] = val;
        list_len++;
        r.ok = 1'b1;
      end
    end else if (p >= 1 && p <= list_len) begin
      r.ok = 1'b1;
      case (op)
        OP_READ: begin
          r.data = list_mem[p-1];
        end
        OP_WRITE: begin
          list_mem[p-1] = val;
        end
        default: begin
          r.data = list_mem[p-1];
          for (i = p - 1; i + 1 < list_len; i++) begin
            list_mem[i] = list_mem[i+1];
          end
          list_len--;
        end
      endcase
    end
    if (list_len > peak_len) begin
      peak_len = list_len;
    end
    r.count = list_len[COUNT_W-1:0];
    r.empty = (list_len == 0);
    return r;
  endfunction

  // Offer one request, hold it until it transfers, then predict its result
  task automatic issue_request(input op_t op, input logic [POS_W-1:0] pos,
                               input logic signed [VAL_W-1:0] val);
    int gap;
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_list_request(op, pos, val));
    n_requests++;
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0000_0000;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Empty list, bad positions, extreme values, insert at front, middle and end
  task automatic test_directed();
    src_idle_pct = 20;
    snk_idle_pct = 20;
    issue_request(OP_READ,   5'd1, $urandom);
    issue_request(OP_WRITE,  5'd1, 32'sh1234_5678);
    issue_request(OP_REMOVE, 5'd1, $urandom);
    issue_request(OP_READ,   5'd0, $urandom);
    issue_request(OP_INSERT, 5'd0, 32'sh0bad_0bad);
    issue_request(OP_INSERT, 5'd2, 32'sh0bad_0bad);
    issue_request(OP_INSERT, 5'd1, 32'sh8000_0000);
    issue_request(OP_INSERT, 5'd2, 32'sh7fff_ffff);
    issue_request(OP_INSERT, 5'd1, 32'sh0000_0000);
    issue_request(OP_INSERT, 5'd2, -32'sd1);
    for (int p = 0; p <= 5; p++) begin
      issue_request(OP_READ, p[POS_W-1:0], $urandom);
    end
    issue_request(OP_WRITE,  5'd3, 32'sh5a5a_a5a5);
    issue_request(OP_WRITE,  5'd5, 32'sh0bad_0bad);
    issue_request(OP_WRITE,  5'd0, 32'sh0bad_0bad);
    issue_request(OP_REMOVE, 5'd2, $urandom);
    issue_request(OP_REMOVE, 5'd3, $urandom);
    issue_request(OP_REMOVE, 5'd0, $urandom);
    issue_request(OP_READ,   5'd31, $urandom);
    issue_request(OP_INSERT, 5'd31, 32'sh0bad_0bad);
  endtask

  // Fill to capacity, poke the full list, then drain it past empty
  task automatic test_full_list();
    src_idle_pct = 15;
    snk_idle_pct = 15;
    while (list_len < LIST_DEPTH) begin
      issue_request(OP_INSERT, POS_W'($urandom_range(1, list_len + 1)), pick_value());
    end
    issue_request(OP_INSERT, 5'd1, $urandom);
    issue_request(OP_INSERT, POS_W'(LIST_DEPTH + 1), $urandom);
    issue_request(OP_INSERT, 5'd31, $urandom);
    issue_request(OP_READ, POS_W'(LIST_DEPTH), $urandom);
    issue_request(OP_READ, POS_W'(LIST_DEPTH + 1), $urandom);
    issue_request(OP_WRITE, POS_W'(LIST_DEPTH), 32'shffff_0000);
    while (list_len > 0) begin
      case ($urandom_range(2))
        0:       issue_request(OP_REMOVE, 5'd1, $urandom);
        1:       issue_request(OP_REMOVE, POS_W'(list_len), $urandom);
        default: issue_request(OP_REMOVE, POS_W'($urandom_range(1, list_len)), $urandom);
      endcase
    end
    issue_request(OP_REMOVE, 5'd1, $urandom);
  endtask

  // Hold the result side for a long stretch while requests keep coming
  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_request = 120;
    for (int k = 0; k < 24; k++) begin
      if (k % 3 == 0 || list_len == 0) begin
        issue_request(OP_INSERT, POS_W'($urandom_range(1, list_len + 1)), pick_value());
      end else begin
        issue_request(OP_READ, POS_W'($urandom_range(1, list_len)), $urandom);
      end
    end
  endtask

  // Random traffic that swings the list between empty and full
  task automatic test_random_traffic(input int n_items, input bit allow_idle);
    int roll;
    bit grow;
    op_t op;
    logic [POS_W-1:0] pos;
    grow = 1'b1;
    for (int k = 0; k < n_items; k++) begin
      if (k % 100 == 0) begin
        src_idle_pct = (allow_idle && $urandom_range(2) != 0) ? 25 : 0;
        snk_idle_pct = (allow_idle && $urandom_range(2) != 0) ? 25 : 0;
        grow = ($urandom_range(1) != 0);
      end
      if (list_len == LIST_DEPTH && $urandom_range(3) == 0) begin
        grow = 1'b0;
      end else if (list_len == 0 && $urandom_range(3) == 0) begin
        grow = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < (grow ? 45 : 15)) begin
        op = OP_INSERT;
      end else if (roll < 60) begin
        op = OP_REMOVE;
      end else if (roll < 80) begin
        op = OP_READ;
      end else begin
        op = OP_WRITE;
      end
      if ($urandom_range(99) < 15) begin
        pos = POS_W'($urandom_range(0, 31));
      end else if (op == OP_INSERT) begin
        pos = POS_W'($urandom_range(1, list_len + 1));
      end else begin
        pos = (list_len > 0) ? POS_W'($urandom_range(1, list_len)) : 5'd1;
      end
      issue_request(op, pos, pick_value());
    end
  endtask

  // Result side: random stall bursts, plus the long hold when requested
  initial begin : drive_out_stall
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        out_stall <= 1'b1;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
        out_stall <= 1'b0;
      end else if (snk_idle_pct > 0 && $urandom_range(99) < snk_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: ok=%0b data=%0d count=%0d empty=%0b",
                 $time, out_ok, out_data, out_count, out_empty_res);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_ok !== want.ok) begin
          $display("%0t: ok mismatch: expected %0b actual %0b", $time, want.ok, out_ok);
          n_errors++;
        end
        if (out_data !== want.data) begin
          $display("%0t: data mismatch: expected %0d actual %0d", $time, want.data, out_data);
          n_errors++;
        end
        if (out_count !== want.count) begin
          $display("%0t: count mismatch: expected %0d actual %0d",
                   $time, want.count, out_count);
          n_errors++;
        end
        if (out_empty_res !== want.empty) begin
          $display("%0t: empty mismatch: expected %0b actual %0b",
                   $time, want.empty, out_empty_res);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending_results.size());
      $display("[positional_list_engine_top] ERROR");
      $finish;
    end
  end

  initial begin : run_tests
    in_valid    <= 1'b0;
    in_opcode   <= OP_READ;
    in_position <= '0;
    in_value    <= '0;
    rst_n       <= 1'b0;
    list_len        = 0;
    src_idle_pct    = 0;
    snk_idle_pct    = 0;
    hold_request    = 0;
    n_requests      = 0;
    n_checked       = 0;
    n_errors        = 0;
    n_full_refusals = 0;
    peak_len        = 0;
    quiet_cycles    = 0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      list_mem[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_list();
    test_backpressure();
    test_random_traffic(1450, 1'b1);
    // closing stretch runs without any idling
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_traffic(200, 1'b0);

    // drain outstanding results, then let the pipeline settle before the summary
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d requests and checked %0d results, %0d field mismatches.",
             n_requests, n_checked, n_errors);
    $display("List peaked at %0d of %0d entries; %0d inserts hit a full list.",
             peak_len, LIST_DEPTH, n_full_refusals);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("[positional_list_engine_top] OK");
    end else begin
      $display("[positional_list_engine_top] ERROR");
    end
    $finish;
  end

endmodule
